// File: src/ort_pkg.sv
// Shared types and constants for the ordered route table.
// Used by the controller, the datapath and the port checker.
`timescale 1ns / 1ps

package ort_pkg;

   localparam int ADDR_W = 32;
   localparam int PLEN_W = 6;
   localparam int POS_W  = 4;

   // command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;
   localparam logic [1:0] ST_PROT = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] net;
      logic [ADDR_W-1:0] hop;
      logic              direct;
      logic [PLEN_W-1:0] plen;
   } entry_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_LAST,
      PTR_POS,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      WA_ZERO,
      WA_UP,
      WA_DOWN
   } wr_at_type;

   typedef struct packed {
      logic       load;
      ptr_op_type ptr_op;
      logic       rd_en;
      logic       wr_en;
      logic       wr_new;
      wr_at_type  wr_at;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       res_load;
      logic [1:0] res_status;
      logic       res_hit;
      logic       rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       empty;
      logic       pos_oor;
      logic       rd_match;
      logic       rd_before;
      logic       rd_direct;
      logic       rd_last;
      logic       rd_zero;
      logic       rd_is_pos;
   } dp_status_type;

   // count of leading one bits; the highest zero bit decides
   function automatic logic [PLEN_W-1:0] prefix_len(input logic [ADDR_W-1:0] m);
      logic [PLEN_W-1:0] n;
      n = PLEN_W'(ADDR_W);
      for (int i = 0; i < ADDR_W; i++) begin
         if (!m[i]) begin
            n = PLEN_W'(ADDR_W - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

// File: src/ordered_route_table.sv
// Ordered IPv4 route table: one word in, one word out, one command at a time.
// A full or empty add, an out-of-range remove, a lookup in an empty table or an unused command
// is answered from the decode state; an add walks from the tail down to its insertion point, a
// remove from the position to the last route or a protected target, a lookup from the first
// route to a hit or the last one. req_ready rises with rsp_valid; a result waits while the
// previous word is unaccepted. Reset empties the table and idles the controller.
`timescale 1ns / 1ps

module ordered_route_table #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic [ort_pkg::ADDR_W-1:0] req_route_mask,
   input  logic [ort_pkg::ADDR_W-1:0] req_route_net,
   input  logic [ort_pkg::ADDR_W-1:0] req_route_next_hop,
   input  logic                       req_route_direct,
   input  logic [ort_pkg::POS_W-1:0]  req_entry_position,
   input  logic [ort_pkg::ADDR_W-1:0] req_dest_addr,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_found,
   output logic [ort_pkg::ADDR_W-1:0] rsp_next_hop
);

   ort_pkg::ctl_cmd_type   cmd;
   ort_pkg::dp_status_type status;

   ort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ort_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_route_mask     (req_route_mask),
      .req_route_net      (req_route_net),
      .req_route_next_hop (req_route_next_hop),
      .req_route_direct   (req_route_direct),
      .req_entry_position (req_entry_position),
      .req_dest_addr      (req_dest_addr),
      .cmd                (cmd),
      .status             (status),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_next_hop       (rsp_next_hop)
   );

endmodule

// File: src/ort_datapath.sv
// Route table datapath: route memory, read/write pointers, route count,
// compare logic and result registers. Depends on ort_pkg.
`timescale 1ns / 1ps

module ort_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_cmd,
   input  logic [ort_pkg::ADDR_W-1:0]   req_route_mask,
   input  logic [ort_pkg::ADDR_W-1:0]   req_route_net,
   input  logic [ort_pkg::ADDR_W-1:0]   req_route_next_hop,
   input  logic                         req_route_direct,
   input  logic [ort_pkg::POS_W-1:0]    req_entry_position,
   input  logic [ort_pkg::ADDR_W-1:0]   req_dest_addr,
   input  ort_pkg::ctl_cmd_type         cmd,
   output ort_pkg::dp_status_type       status,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_found,
   output logic [ort_pkg::ADDR_W-1:0]   rsp_next_hop
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > ort_pkg::POS_W) ? CNT_W : ort_pkg::POS_W;

   ort_pkg::entry_type mem [ENTRIES];

   logic [1:0]                 req_cmd_ff;
   ort_pkg::entry_type         req_entry_ff;
   logic [ort_pkg::POS_W-1:0]  req_pos_ff;
   logic [ort_pkg::ADDR_W-1:0] req_dest_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] rd_addr_ff;
   ort_pkg::entry_type rdata_ff;

   logic [1:0]                 res_status_ff;
   logic                       res_found_ff;
   logic [ort_pkg::ADDR_W-1:0] res_hop_ff;
   logic [1:0]                 rsp_status_ff;
   logic                       rsp_found_ff;
   logic [ort_pkg::ADDR_W-1:0] rsp_next_hop_ff;

   logic [CNT_W-1:0]   last_idx;
   logic [CNT_W-1:0]   wr_addr;
   ort_pkg::entry_type wr_data;
   logic               rd_ok;

   assign last_idx = count_ff - CNT_W'(1);
   assign rd_ok    = ptr_ff < CNT_W'(ENTRIES);
   assign wr_data  = cmd.wr_new ? req_entry_ff : rdata_ff;

   always_comb begin
      case (cmd.ptr_op)
         ort_pkg::PTR_ZERO: ptr_in = '0;
         ort_pkg::PTR_LAST: ptr_in = last_idx;
         ort_pkg::PTR_POS:  ptr_in = CNT_W'(req_pos_ff);
         ort_pkg::PTR_INC:  ptr_in = ptr_ff + CNT_W'(1);
         ort_pkg::PTR_DEC:  ptr_in = ptr_ff - CNT_W'(1);
         default:           ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_at)
         ort_pkg::WA_UP:   wr_addr = rd_addr_ff + CNT_W'(1);
         ort_pkg::WA_DOWN: wr_addr = rd_addr_ff - CNT_W'(1);
         default:          wr_addr = '0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // route memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en && rd_ok) begin
         rdata_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.rd_en) begin
         rd_addr_ff <= ptr_ff;
      end
      if (cmd.load) begin
         req_cmd_ff          <= req_cmd;
         req_entry_ff.mask   <= req_route_mask;
         req_entry_ff.net    <= req_route_net;
         req_entry_ff.hop    <= req_route_next_hop;
         req_entry_ff.direct <= req_route_direct;
         req_entry_ff.plen   <= ort_pkg::prefix_len(req_route_mask);
         req_pos_ff          <= req_entry_position;
         req_dest_ff         <= req_dest_addr;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_found_ff  <= cmd.res_hit;
         res_hop_ff    <= (cmd.res_hit && !rdata_ff.direct) ? rdata_ff.hop : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff   <= res_status_ff;
         rsp_found_ff    <= res_found_ff;
         rsp_next_hop_ff <= res_hop_ff;
      end
   end

   always_comb begin
      status.cmd       = req_cmd_ff;
      status.full      = count_ff == CNT_W'(ENTRIES);
      status.empty     = count_ff == '0;
      status.pos_oor   = CMP_W'(req_pos_ff) >= CMP_W'(count_ff);
      status.rd_match  = (rdata_ff.mask & req_dest_ff) == rdata_ff.net;
      // stored route stays ahead of the new one
      status.rd_before = !req_entry_ff.direct &&
                         (rdata_ff.direct || (rdata_ff.plen >= req_entry_ff.plen));
      status.rd_direct = rdata_ff.direct;
      status.rd_last   = rd_addr_ff == last_idx;
      status.rd_zero   = rd_addr_ff == '0;
      status.rd_is_pos = CMP_W'(rd_addr_ff) == CMP_W'(req_pos_ff);
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_next_hop = rsp_next_hop_ff;

endmodule

// File: src/ort_ctrl.sv
// Route table controller: sequences add, remove and lookup walks over the
// route memory and drives the handshakes. Depends on ort_pkg.
`timescale 1ns / 1ps

module ort_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ort_pkg::dp_status_type status,
   output ort_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC,
      S_ADD,
      S_ADD0,
      S_REM,
      S_LOOK,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rv_in        = (state_ff == S_ADD) || (state_ff == S_REM) || (state_ff == S_LOOK);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end

         S_DEC: begin
            cmd.res_status = ort_pkg::ST_MISS;
            case (status.cmd)
               ort_pkg::CMD_ADD: begin
                  if (status.full) begin
                     cmd.res_status = ort_pkg::ST_FULL;
                     cmd.res_load   = 1'b1;
                     state_in       = S_FIN;
                  end else if (status.empty) begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_new     = 1'b1;
                     cmd.wr_at      = ort_pkg::WA_ZERO;
                     cmd.cnt_inc    = 1'b1;
                     cmd.res_status = ort_pkg::ST_OK;
                     cmd.res_load   = 1'b1;
                     state_in       = S_FIN;
                  end else begin
                     cmd.ptr_op = ort_pkg::PTR_LAST;
                     state_in   = S_ADD;
                  end
               end
               ort_pkg::CMD_REMOVE: begin
                  if (status.pos_oor) begin
                     cmd.res_load = 1'b1;
                     state_in     = S_FIN;
                  end else begin
                     cmd.ptr_op = ort_pkg::PTR_POS;
                     state_in   = S_REM;
                  end
               end
               ort_pkg::CMD_LOOKUP: begin
                  if (status.empty) begin
                     cmd.res_load = 1'b1;
                     state_in     = S_FIN;
                  end else begin
                     cmd.ptr_op = ort_pkg::PTR_ZERO;
                     state_in   = S_LOOK;
                  end
               end
               default: begin
                  cmd.res_load = 1'b1;
                  state_in     = S_FIN;
               end
            endcase
         end

         // walk down from the tail, moving routes up one slot until the
         // insertion point shows up
         S_ADD: begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = ort_pkg::PTR_DEC;
            cmd.wr_at  = ort_pkg::WA_UP;
            if (rv_ff) begin
               cmd.wr_en = 1'b1;
               if (status.rd_before) begin
                  cmd.wr_new     = 1'b1;
                  cmd.cnt_inc    = 1'b1;
                  cmd.res_status = ort_pkg::ST_OK;
                  cmd.res_load   = 1'b1;
                  state_in       = S_FIN;
               end else if (status.rd_zero) begin
                  state_in = S_ADD0;
               end
            end
         end

         S_ADD0: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_new     = 1'b1;
            cmd.wr_at      = ort_pkg::WA_ZERO;
            cmd.cnt_inc    = 1'b1;
            cmd.res_status = ort_pkg::ST_OK;
            cmd.res_load   = 1'b1;
            state_in       = S_FIN;
         end

         // first read checks the target, later ones move routes down a slot
         S_REM: begin
            cmd.rd_en      = 1'b1;
            cmd.ptr_op     = ort_pkg::PTR_INC;
            cmd.wr_at      = ort_pkg::WA_DOWN;
            cmd.res_status = ort_pkg::ST_OK;
            if (rv_ff) begin
               if (status.rd_is_pos) begin
                  if (status.rd_direct) begin
                     cmd.res_status = ort_pkg::ST_PROT;
                     cmd.res_load   = 1'b1;
                     state_in       = S_FIN;
                  end else if (status.rd_last) begin
                     cmd.cnt_dec  = 1'b1;
                     cmd.res_load = 1'b1;
                     state_in     = S_FIN;
                  end
               end else begin
                  cmd.wr_en = 1'b1;
                  if (status.rd_last) begin
                     cmd.cnt_dec  = 1'b1;
                     cmd.res_load = 1'b1;
                     state_in     = S_FIN;
                  end
               end
            end
         end

         S_LOOK: begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = ort_pkg::PTR_INC;
            if (rv_ff) begin
               if (status.rd_match) begin
                  cmd.res_status = ort_pkg::ST_OK;
                  cmd.res_hit    = 1'b1;
                  cmd.res_load   = 1'b1;
                  state_in       = S_FIN;
               end else if (status.rd_last) begin
                  cmd.res_status = ort_pkg::ST_MISS;
                  cmd.res_load   = 1'b1;
                  state_in       = S_FIN;
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/ort_checker.sv
// Port-level checks for the ordered route table, bound to the top level.
// Depends on ort_pkg.
`timescale 1ns / 1ps

module ort_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic                       rsp_found,
   input logic [ort_pkg::ADDR_W-1:0] rsp_next_hop
);

   // a waiting result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_next_hop)))
      else $error("result word changed while stalled");

   // one command in flight: no second accept right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted twice in a row");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ort_pkg::ST_OK))
      else $error("match reported with non-ok status");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_next_hop == '0))
      else $error("next hop set without a match");

endmodule

bind ordered_route_table ort_checker u_ort_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_found    (rsp_found),
   .rsp_next_hop (rsp_next_hop)
);

// File: tb/route_checker.sv
// Port checker for the ordered route table: keeps its own copy of the route
// list, predicts each response word and compares it. Depends on ort_pkg.
`timescale 1ns / 1ps

module route_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic [ort_pkg::ADDR_W-1:0] req_route_mask,
   input  logic [ort_pkg::ADDR_W-1:0] req_route_net,
   input  logic [ort_pkg::ADDR_W-1:0] req_route_next_hop,
   input  logic                       req_route_direct,
   input  logic [ort_pkg::POS_W-1:0]  req_entry_position,
   input  logic [ort_pkg::ADDR_W-1:0] req_dest_addr,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_status,
   input  logic                       rsp_found,
   input  logic [ort_pkg::ADDR_W-1:0] rsp_next_hop,
   output int                         errors,
   output int                         pending
);

   typedef struct packed {
      logic [ort_pkg::ADDR_W-1:0] mask;
      logic [ort_pkg::ADDR_W-1:0] net;
      logic [ort_pkg::ADDR_W-1:0] hop;
      logic                       direct;
   } route_slot_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic                       found;
      logic [ort_pkg::ADDR_W-1:0] next_hop;
   } route_answer_type;

   route_slot_type   routes [ENTRIES];
   int               route_total;
   route_answer_type answers_due [$];
   int               fail_total = 0;

   function automatic int lead_ones(input logic [ort_pkg::ADDR_W-1:0] m);
      int n;
      n = 0;
      while (n < ort_pkg::ADDR_W && m[ort_pkg::ADDR_W-1-n]) n++;
      return n;
   endfunction

   // updates the route list for one command word and returns the answer
   function automatic route_answer_type route_table_step(
      input logic [1:0]                 cmd,
      input logic [ort_pkg::ADDR_W-1:0] mask,
      input logic [ort_pkg::ADDR_W-1:0] net,
      input logic [ort_pkg::ADDR_W-1:0] hop,
      input logic                       direct,
      input logic [ort_pkg::POS_W-1:0]  pos,
      input logic [ort_pkg::ADDR_W-1:0] dest
   );
      route_answer_type ans;
      int at;
      int i;
      ans = '{status: ort_pkg::ST_MISS, found: 1'b0, next_hop: '0};
      case (cmd)
         ort_pkg::CMD_ADD: begin
            if (route_total >= ENTRIES) begin
               ans.status = ort_pkg::ST_FULL;
            end else begin
               at = 0;
               // non-direct routes land after directs and after equal or longer prefixes
               if (!direct) begin
                  while (at < route_total && (routes[at].direct ||
                         lead_ones(routes[at].mask) >= lead_ones(mask))) at++;
               end
               for (i = route_total; i > at; i--) routes[i] = routes[i-1];
               routes[at] = '{mask: mask, net: net, hop: hop, direct: direct};
               route_total++;
               ans.status = ort_pkg::ST_OK;
            end
         end
         ort_pkg::CMD_REMOVE: begin
            if (int'(pos) >= route_total) begin
               ans.status = ort_pkg::ST_MISS;
            end else if (routes[pos].direct) begin
               ans.status = ort_pkg::ST_PROT;
            end else begin
               for (i = int'(pos); i + 1 < route_total; i++) routes[i] = routes[i+1];
               route_total--;
               ans.status = ort_pkg::ST_OK;
            end
         end
         ort_pkg::CMD_LOOKUP: begin
            for (i = 0; i < route_total && !ans.found; i++) begin
               if ((routes[i].mask & dest) == routes[i].net) begin
                  ans.status   = ort_pkg::ST_OK;
                  ans.found    = 1'b1;
                  ans.next_hop = routes[i].direct ? '0 : routes[i].hop;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      route_answer_type want;
      if (reset) begin
         route_total = 0;
         answers_due.delete();
      end else begin
         // response first: it always belongs to an older word
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response word status %0d found %0d next_hop %h",
                        $time, rsp_status, rsp_found, rsp_next_hop);
               fail_total++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
                  fail_total++;
               end
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0d got %0d", $time, want.found, rsp_found);
                  fail_total++;
               end
               if (rsp_next_hop !== want.next_hop) begin
                  $display("%0t: next_hop expected %h got %h",
                           $time, want.next_hop, rsp_next_hop);
                  fail_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            answers_due.push_back(route_table_step(req_cmd, req_route_mask, req_route_net,
                                                   req_route_next_hop, req_route_direct,
                                                   req_entry_position, req_dest_addr));
         end
      end
      errors  <= fail_total;
      pending <= answers_due.size();
   end

endmodule

// File: tb/tb.sv
// Top of the route table testbench: clock, reset, command stimulus and verdict.
// Depends on ort_pkg, ordered_route_table and route_checker.
`timescale 1ns / 1ps

module tb;

   localparam int         ROUTE_SLOTS = 16;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_cmd = ort_pkg::CMD_LOOKUP;
   logic [ort_pkg::ADDR_W-1:0] req_route_mask = '0;
   logic [ort_pkg::ADDR_W-1:0] req_route_net = '0;
   logic [ort_pkg::ADDR_W-1:0] req_route_next_hop = '0;
   logic                       req_route_direct = 1'b0;
   logic [ort_pkg::POS_W-1:0]  req_entry_position = '0;
   logic [ort_pkg::ADDR_W-1:0] req_dest_addr = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_status;
   logic                       rsp_found;
   logic [ort_pkg::ADDR_W-1:0] rsp_next_hop;
   int                         errors;
   int                         pending;

   int                         send_idle_pct = 12;
   int                         recv_idle_pct = 53;
   int                         direct_budget = 5;
   logic [ort_pkg::ADDR_W-1:0] addr_pool [4];

   always #5 clock = ~clock;

   ordered_route_table #(.ENTRIES(ROUTE_SLOTS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_route_mask     (req_route_mask),
      .req_route_net      (req_route_net),
      .req_route_next_hop (req_route_next_hop),
      .req_route_direct   (req_route_direct),
      .req_entry_position (req_entry_position),
      .req_dest_addr      (req_dest_addr),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_next_hop       (rsp_next_hop)
   );

   route_checker #(.ENTRIES(ROUTE_SLOTS)) u_route_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_route_mask     (req_route_mask),
      .req_route_net      (req_route_net),
      .req_route_next_hop (req_route_next_hop),
      .req_route_direct   (req_route_direct),
      .req_entry_position (req_entry_position),
      .req_dest_addr      (req_dest_addr),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_next_hop       (rsp_next_hop),
      .errors             (errors),
      .pending            (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [ort_pkg::ADDR_W-1:0] prefix_mask(input int n);
      return (n == 0) ? '0 : ~32'h0 << (ort_pkg::ADDR_W - n);
   endfunction

   // word is held until accepted; valid stays up when the next word follows at once
   task automatic send_word(
      input logic [1:0]                 cmd,
      input logic [ort_pkg::ADDR_W-1:0] mask,
      input logic [ort_pkg::ADDR_W-1:0] net,
      input logic [ort_pkg::ADDR_W-1:0] hop,
      input logic                       direct,
      input logic [ort_pkg::POS_W-1:0]  pos,
      input logic [ort_pkg::ADDR_W-1:0] dest
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_route_mask     <= mask;
      req_route_net      <= net;
      req_route_next_hop <= hop;
      req_route_direct   <= direct;
      req_entry_position <= pos;
      req_dest_addr      <= dest;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic add_route(input logic [ort_pkg::ADDR_W-1:0] mask,
                            input logic [ort_pkg::ADDR_W-1:0] net,
                            input logic [ort_pkg::ADDR_W-1:0] hop, input logic direct);
      send_word(ort_pkg::CMD_ADD, mask, net, hop, direct, 4'($urandom), $urandom);
   endtask

   task automatic remove_route(input logic [ort_pkg::POS_W-1:0] pos);
      send_word(ort_pkg::CMD_REMOVE, $urandom, $urandom, $urandom, 1'($urandom), pos,
                $urandom);
   endtask

   task automatic look_up(input logic [ort_pkg::ADDR_W-1:0] dest);
      send_word(ort_pkg::CMD_LOOKUP, $urandom, $urandom, $urandom, 1'($urandom),
                4'($urandom), dest);
   endtask

   // mostly routes and addresses around a few shared bases so lookups hit
   task automatic send_random_word();
      int                         pick;
      int                         k;
      logic [1:0]                 cmd;
      logic [ort_pkg::ADDR_W-1:0] mask;
      logic [ort_pkg::ADDR_W-1:0] net;
      logic [ort_pkg::ADDR_W-1:0] dest;
      logic [63:0]                span;
      logic                       direct;
      pick = $urandom_range(99);
      if (pick < 30) cmd = ort_pkg::CMD_ADD;
      else if (pick < 65) cmd = ort_pkg::CMD_REMOVE;
      else if (pick < 95) cmd = ort_pkg::CMD_LOOKUP;
      else cmd = CMD_UNUSED;
      k    = $urandom_range(3);
      mask = ($urandom_range(99) < 85) ? prefix_mask($urandom_range(32)) : $urandom;
      net  = ($urandom_range(99) < 80) ? (addr_pool[k] & mask) : $urandom;
      span = (64'd1 << $urandom_range(32)) - 64'd1;
      dest = ($urandom_range(99) < 85) ? (addr_pool[k] ^ ($urandom & span[31:0])) : $urandom;
      // directs can never be removed; keep them few so the table stays usable
      direct = 1'b0;
      if (cmd == ort_pkg::CMD_ADD && direct_budget > 0 && $urandom_range(99) < 4) begin
         direct = 1'b1;
         direct_budget--;
      end
      else if (cmd != ort_pkg::CMD_ADD) begin
         direct = 1'($urandom);
      end
      send_word(cmd, mask, net, $urandom, direct, 4'($urandom_range(15)), dest);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, unused command
      look_up(32'hC0A8_0101);
      remove_route(4'd0);
      send_word(CMD_UNUSED, '1, '1, '1, 1'b1, '1, '1);
      // directs, default route, prefix extremes, non-contiguous mask
      add_route(32'hFFFF_FF00, 32'h0A00_0100, 32'h1234_5678, 1'b1);
      add_route(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      add_route(32'hFFFF_FFFF, 32'hC0A8_0101, 32'h0101_0101, 1'b0);
      add_route(32'hFFFF_0000, 32'hC0A8_0000, 32'h0202_0202, 1'b0);
      add_route(32'hFF00_FF00, 32'h1100_2200, 32'h0404_0404, 1'b0);
      add_route(32'hFFFF_FFFF, 32'hC0A8_0102, 32'hFFFF_FFFF, 1'b1);
      look_up(32'h0A00_0155);
      look_up(32'hC0A8_0101);
      look_up(32'hC0A8_0102);
      look_up(32'h11AA_22BB);
      remove_route(4'd0);
      remove_route(4'd2);
      look_up(32'hC0A8_0101);
      // fill to the last slot and one past it
      repeat (12) add_route(prefix_mask($urandom_range(32)), $urandom, $urandom, 1'b0);

      repeat (270) send_random_word();
      drain_answers();
      send_idle_pct = 53;
      recv_idle_pct = 12;
      repeat (270) send_random_word();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (270) send_random_word();

      drain_answers();
      repeat (30) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
